>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tlfr_pkg.sv
// ---------------------------------------------------------------------------
// tlfr_pkg
// Shared widths, register indexes and reset values of the frame receiver.
// ---------------------------------------------------------------------------
package tlfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int CNT_W      = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_FRAME_DEF = 64;

   // Tags at or above this value never open a frame.
   localparam int TAG_LIMIT = 64;
   localparam logic [BYTE_W-1:0] TAG_MIN = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_BYTE    = 2'd0,
      CSR_END_BYTE      = 2'd1,
      CSR_ACCEPTED_TAGS = 2'd2
   } csr_index_type;

   localparam logic [BYTE_W-1:0]     START_BYTE_RST    = 8'd2;
   localparam logic [BYTE_W-1:0]     END_BYTE_RST      = 8'd3;
   localparam logic [CSR_DATA_W-1:0] ACCEPTED_TAGS_RST = '0;

   localparam logic RESULT_FRAME   = 1'b0;
   localparam logic RESULT_DISCARD = 1'b1;

endpackage

>>> sv/tlfr_ram.sv
// ---------------------------------------------------------------------------
// tlfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module tlfr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tag_length_frame_receiver.sv
// ---------------------------------------------------------------------------
// tag_length_frame_receiver
// Start / tag-length / payload / end-byte deframer with frame buffer RAM.
// ---------------------------------------------------------------------------
//
//   channel  | ports                        | dir | transaction
//   ---------+------------------------------+-----+----------------------------
//   req      | req_valid/ready, req_rx_byte | in  | one received byte
//   rsp      | rsp_valid/ready, 5 fields    | out | one frame byte or a discard
//   csr      | csr_wr_en/index/wr_data      | in  | register write, no wait
//
// Flow: a received byte is accepted while hunting, waiting for a tag or
//   filling the frame buffer. After a good end byte the frame of L bytes is
//   read back from the buffer RAM, one read per cycle while rsp_ready is
//   held high; req_ready is low during playout.
// Reset: synchronous, clears phase, counters and the output valid flag. The
//   buffer RAM is not cleared; playout only reads entries of the current frame.
// Stalls: rsp backpressure holds the RAM read data; an end-position byte waits
//   for a free output register; other bytes are taken while a result waits.
//
module tag_length_frame_receiver #(
   parameter int MAX_FRAME = tlfr_pkg::MAX_FRAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tlfr_pkg::BYTE_W-1:0]     req_rx_byte,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_result_kind,
   output logic [tlfr_pkg::BYTE_W-1:0]     rsp_frame_byte,
   output logic [tlfr_pkg::POS_W-1:0]      rsp_byte_position,
   output logic                            rsp_last_of_frame,
   output logic [tlfr_pkg::CNT_W-1:0]      rsp_discard_total,

   input  logic                            csr_wr_en,
   input  logic [tlfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlfr_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import tlfr_pkg::*;

   // Buffer address width; positions never reach MAX_FRAME.
   localparam int AW = $clog2(MAX_FRAME);
   localparam logic [BYTE_W:0] MAX_LEN = (BYTE_W+1)'(MAX_FRAME);

   typedef enum logic [1:0] {
      PH_HUNT,   // looking for the start byte
      PH_TAG,    // next byte is the tag / length
      PH_RECV,   // storing payload up to the end position
      PH_PLAY    // reading the frame back out
   } phase_type;

   // Config registers
   logic [BYTE_W-1:0]     start_byte_ff,    start_byte_in;
   logic [BYTE_W-1:0]     end_byte_ff,      end_byte_in;
   logic [CSR_DATA_W-1:0] accepted_tags_ff, accepted_tags_in;

   // Control state
   phase_type         phase_ff,     phase_in;
   logic [AW-1:0]     wp_ff,        wp_in;        // next write position
   logic [AW-1:0]     lastpos_ff,   lastpos_in;   // frame length - 1
   logic [CNT_W-1:0]  discard_ff,   discard_in;
   logic [AW-1:0]     rd_ptr_ff,    rd_ptr_in;    // next playout read address
   logic              issued_all_ff, issued_all_in;
   logic              pend_ff,      pend_in;      // RAM read data not yet used
   logic [AW-1:0]     rd_pos_ff,    rd_pos_in;    // address behind rd_data

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              kind_ff,      kind_in;
   logic [BYTE_W-1:0] fbyte_ff,     fbyte_in;
   logic [POS_W-1:0]  pos_ff,       pos_in;
   logic              last_ff,      last_in;
   logic [CNT_W-1:0]  total_ff,     total_in;

   // RAM ports
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic              ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;

   logic req_fire;
   logic out_free;
   logic at_end;
   logic tag_ok;
   logic load;
   logic issue;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_end   = (wp_ff >= lastpos_ff);

   // A tag opens a frame only if it is in 3..63, fits the buffer and is enabled.
   assign tag_ok = (req_rx_byte >= TAG_MIN)
                && (req_rx_byte < BYTE_W'(TAG_LIMIT))
                && ({1'b0, req_rx_byte} <= MAX_LEN)
                && accepted_tags_ff[req_rx_byte[5:0]];

   // Input is held during playout; a discard needs the output register free.
   assign req_ready = (phase_ff != PH_PLAY)
                   && !((phase_ff == PH_RECV) && at_end && !out_free);
   assign req_fire  = req_valid && req_ready;

   // Playout: one read in flight, the next one issued as the data moves out.
   assign load  = pend_ff && out_free;
   assign issue = (phase_ff == PH_PLAY) && !issued_all_ff && (!pend_ff || load);
   assign ram_rd_en = issue;

   // Config writes
   always_comb begin
      start_byte_in    = start_byte_ff;
      end_byte_in      = end_byte_ff;
      accepted_tags_in = accepted_tags_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_BYTE:    start_byte_in    = csr_wr_data[BYTE_W-1:0];
            CSR_END_BYTE:      end_byte_in      = csr_wr_data[BYTE_W-1:0];
            CSR_ACCEPTED_TAGS: accepted_tags_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Frame state machine
   always_comb begin
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      lastpos_in    = lastpos_ff;
      discard_in    = discard_ff;
      rd_ptr_in     = rd_ptr_ff;
      issued_all_in = issued_all_ff;
      rd_pos_in     = rd_pos_ff;
      pend_in       = pend_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      fbyte_in      = fbyte_ff;
      pos_in        = pos_ff;
      last_in       = last_ff;
      total_in      = total_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = wp_ff;

      unique case (phase_ff)
         PH_HUNT: begin
            if (req_fire) begin
               wp_in = '0;
               if (req_rx_byte == start_byte_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = '0;
                  wp_in       = AW'(1);
                  phase_in    = PH_TAG;
               end
            end
         end
         PH_TAG: begin
            if (req_fire && tag_ok) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(1);
               lastpos_in  = AW'(req_rx_byte - 8'd1);
               wp_in       = AW'(2);
               phase_in    = PH_RECV;
            end
         end
         PH_RECV: begin
            if (req_fire) begin
               if (at_end) begin
                  wp_in = '0;
                  if (req_rx_byte == end_byte_ff) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = lastpos_ff;
                     rd_ptr_in     = '0;
                     issued_all_in = 1'b0;
                     phase_in      = PH_PLAY;
                  end else begin
                     discard_in   = discard_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                     kind_in      = RESULT_DISCARD;
                     fbyte_in     = '0;
                     pos_in       = POS_W'(lastpos_ff);
                     last_in      = 1'b1;
                     total_in     = discard_ff + 1'b1;
                     phase_in     = PH_HUNT;
                  end
               end else begin
                  ram_wr_en = 1'b1;
                  wp_in     = wp_ff + 1'b1;
               end
            end
         end
         PH_PLAY: begin
            if (load) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               kind_in      = RESULT_FRAME;
               fbyte_in     = ram_rd_data;
               pos_in       = POS_W'(rd_pos_ff);
               last_in      = (rd_pos_ff == lastpos_ff);
               total_in     = discard_ff;
               if (rd_pos_ff == lastpos_ff) begin
                  phase_in = PH_HUNT;
               end
            end
            if (issue) begin
               pend_in   = 1'b1;
               rd_pos_in = rd_ptr_ff;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (rd_ptr_ff == lastpos_ff) begin
                  issued_all_in = 1'b1;
               end
            end
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= START_BYTE_RST;
         end_byte_ff      <= END_BYTE_RST;
         accepted_tags_ff <= ACCEPTED_TAGS_RST;
         phase_ff         <= PH_HUNT;
         wp_ff            <= '0;
         lastpos_ff       <= '0;
         discard_ff       <= '0;
         rd_ptr_ff        <= '0;
         issued_all_ff    <= 1'b1;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_byte_ff    <= start_byte_in;
         end_byte_ff      <= end_byte_in;
         accepted_tags_ff <= accepted_tags_in;
         phase_ff         <= phase_in;
         wp_ff            <= wp_in;
         lastpos_ff       <= lastpos_in;
         discard_ff       <= discard_in;
         rd_ptr_ff        <= rd_ptr_in;
         issued_all_ff    <= issued_all_in;
         pend_ff          <= pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      // payload, no reset needed
      rd_pos_ff <= rd_pos_in;
      kind_ff   <= kind_in;
      fbyte_ff  <= fbyte_in;
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      total_ff  <= total_in;
   end

   tlfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FRAME)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_frame_byte    = fbyte_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_discard_total = total_ff;

endmodule

>>> sv/tlfr_checker.sv
// ---------------------------------------------------------------------------
// tlfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_result_kind,
   input logic [tlfr_pkg::BYTE_W-1:0]     rsp_frame_byte,
   input logic [tlfr_pkg::POS_W-1:0]      rsp_byte_position,
   input logic                            rsp_last_of_frame,
   input logic [tlfr_pkg::CNT_W-1:0]      rsp_discard_total
);

   import tlfr_pkg::*;

   localparam int PAYLOAD_W = 2 + BYTE_W + POS_W + CNT_W;

   logic                 rsp_fire;
   logic                 rsp_stall;
   logic [PAYLOAD_W-1:0] rsp_payload;
   logic                 is_discard;
   logic                 discard_out;
   logic                 discard_ok;
   logic                 mid_frame;
   logic                 mid_valid;
   logic                 mid_fire;
   logic                 tag_out;
   logic                 tag_byte_ok;

   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_result_kind, rsp_frame_byte, rsp_byte_position,
                         rsp_last_of_frame, rsp_discard_total};
   assign is_discard  = (rsp_result_kind == RESULT_DISCARD);
   assign discard_out = rsp_valid && is_discard;
   assign discard_ok  = (rsp_frame_byte == '0) && rsp_last_of_frame
                     && (rsp_byte_position >= POS_W'(2));
   assign mid_frame   = !is_discard && !rsp_last_of_frame;
   assign mid_valid   = rsp_valid && mid_frame;
   assign mid_fire    = rsp_fire && mid_frame;
   assign tag_out     = rsp_valid && !is_discard && (rsp_byte_position == POS_W'(1));
   assign tag_byte_ok = (rsp_frame_byte >= TAG_MIN)
                     && (rsp_frame_byte < BYTE_W'(TAG_LIMIT));

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload), "rsp moved")

   // discard shows a zero byte, closes the run, sits at position 2 or above
   `ASSERT_IMPLIES(a_discard_shape, clock, reset, discard_out, discard_ok, "bad discard")

   // tag byte of a played frame is a legal length
   `ASSERT_IMPLIES(a_tag_range, clock, reset, tag_out, tag_byte_ok, "bad tag byte")

   // no discard can show up in the middle of a frame
   `ASSERT_NEXT(a_no_discard_mid, clock, reset, mid_fire, !discard_out, "discard inside frame")

   // input stays closed while a frame is still playing out
   `ASSERT_IMPLIES(a_req_closed, clock, reset, mid_valid, !req_ready, "req open in playout")

endmodule

bind tag_length_frame_receiver tlfr_checker u_tlfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_frame_byte    (rsp_frame_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_last_of_frame (rsp_last_of_frame),
   .rsp_discard_total (rsp_discard_total)
);
